[rtl/core/fce_pkg.sv]
// Shared types, codes and constants of the packed 12-bit link table engine.
package fce_pkg;

   localparam int FCE_ENTRIES = 4096;

   localparam logic [11:0] LINK_END_TABLE = 12'hFFA;
   localparam logic [11:0] LINK_FREE      = 12'hFFF;
   localparam logic [11:0] LINK_LAST      = 12'hFFE;

   localparam logic [2:0] KIND_READ_LINK  = 3'd0;
   localparam logic [2:0] KIND_WRITE_LINK = 3'd1;
   localparam logic [2:0] KIND_ALLOCATE   = 3'd2;
   localparam logic [2:0] KIND_FREE_CHAIN = 3'd3;
   localparam logic [2:0] KIND_LOAD_BYTE  = 3'd4;
   localparam logic [2:0] KIND_READ_BYTE  = 3'd5;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_FREE = 2'd1;
   localparam logic [1:0] ST_UNTERM  = 2'd2;
   localparam logic [1:0] ST_RANGE   = 2'd3;

   typedef enum logic [2:0] {
      OP_DONE   = 3'd0,
      OP_RLINK  = 3'd1,
      OP_WLINK  = 3'd2,
      OP_ALLOC  = 3'd3,
      OP_FREE   = 3'd4,
      OP_LDBYTE = 3'd5,
      OP_RDBYTE = 3'd6
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [1:0]  status;
      logic [11:0] idx;
      logic [11:0] val;
      logic [12:0] addr;
      logic [7:0]  data;
   } cmd_type;

endpackage

[rtl/core/fce_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/fce_front.sv]
// Input side: takes request words, range-checks and classifies them into commands.
module fce_front import fce_pkg::*; #(
   parameter int ENTRIES = FCE_ENTRIES
) (
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [11:0] req_entry_index,
   input  logic [11:0] req_link_value,
   input  logic [12:0] req_byte_address,
   input  logic [7:0]  req_byte_data,
   input  logic        q_full,
   output logic        q_push,
   output cmd_type     q_cmd
);

   localparam int STORE_BYTES = (3 * ENTRIES + 1) / 2;

   logic idx_bad;
   logic addr_bad;

   assign idx_bad   = {1'b0, req_entry_index} >= 13'(ENTRIES);
   assign addr_bad  = req_byte_address >= 13'(STORE_BYTES);
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_cmd.op     = OP_DONE;
      q_cmd.status = ST_OK;
      q_cmd.idx    = req_entry_index;
      q_cmd.val    = req_link_value;
      q_cmd.addr   = req_byte_address;
      q_cmd.data   = req_byte_data;
      case (req_kind)
         KIND_READ_LINK: begin
            if (idx_bad) q_cmd.status = ST_RANGE;
            else q_cmd.op = OP_RLINK;
         end
         KIND_WRITE_LINK: begin
            if (idx_bad) q_cmd.status = ST_RANGE;
            else q_cmd.op = OP_WLINK;
         end
         KIND_ALLOCATE: begin
            q_cmd.op = OP_ALLOC;
         end
         KIND_FREE_CHAIN: begin
            if (req_entry_index == LINK_LAST) q_cmd.status = ST_OK;
            else if (idx_bad) q_cmd.status = ST_RANGE;
            else q_cmd.op = OP_FREE;
         end
         KIND_LOAD_BYTE: begin
            if (addr_bad) q_cmd.status = ST_RANGE;
            else q_cmd.op = OP_LDBYTE;
         end
         KIND_READ_BYTE: begin
            if (addr_bad) q_cmd.status = ST_RANGE;
            else q_cmd.op = OP_RDBYTE;
         end
         default: begin
         end
      endcase
   end

endmodule

[rtl/core/fce_queue.sv]
// Two-entry command queue between the front and back parts.
module fce_queue import fce_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type cmd_in,
   output logic    full,
   output logic    valid,
   output cmd_type cmd_out,
   input  logic    pop
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_pop;

   assign full    = count_ff == 2'd2;
   assign valid   = count_ff != 2'd0;
   assign cmd_out = slot_ff[rd_ptr_ff];
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

[rtl/core/fce_back.sv]
// Execution: link read/write, allocate scan, chain free, byte load/read on the store.
module fce_back import fce_pkg::*; #(
   parameter int ENTRIES = FCE_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  cmd_type     q_cmd,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_link_out,
   output logic [7:0]  rsp_byte_out,
   output logic [1:0]  rsp_status,
   output logic        rsp_table_dirty
);

   localparam int STORE_BYTES = (3 * ENTRIES + 1) / 2;
   localparam int BANK_DEPTH  = (STORE_BYTES + 1) / 2;
   localparam int BANK_AW     = $clog2(BANK_DEPTH);
   localparam int CNT_W       = $clog2(ENTRIES);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_EVAL = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [11:0]      cur_ff, cur_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             dirty_ff, dirty_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [11:0]      rsp_link_ff, rsp_link_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic             rsp_dirty_ff, rsp_dirty_in;
   logic             out_load;
   logic             out_free;

   logic [12:0]        ent_addr;
   logic [12:0]        a_sel;
   logic [BANK_AW-1:0] half;
   logic [BANK_AW-1:0] even_rd, odd_rd;
   logic [BANK_AW-1:0] even_wa, odd_wa;
   logic [7:0]         even_q, odd_q;
   logic [7:0]         even_wd, odd_wd;
   logic               even_we, odd_we;
   logic [7:0]         b0, b1, nb0, nb1;
   logic [11:0]        entry_val;
   logic [11:0]        put_v;
   logic               put_en;

   // Entry n starts at byte n + n/2; even bytes and odd bytes live in separate banks.
   assign ent_addr = {1'b0, cur_ff} + {2'b00, cur_ff[11:1]};
   assign a_sel    = (cmd_ff.op == OP_RDBYTE) ? cmd_ff.addr : ent_addr;
   assign half     = a_sel[BANK_AW:1];
   assign even_rd  = half + BANK_AW'(a_sel[0]);
   assign odd_rd   = half;

   assign b0        = a_sel[0] ? odd_q : even_q;
   assign b1        = a_sel[0] ? even_q : odd_q;
   assign entry_val = cur_ff[0] ? {b0[3:0], b1} : {b1[7:4], b0};

   always_comb begin
      case (cmd_ff.op)
         OP_WLINK: put_v = cmd_ff.val;
         OP_ALLOC: put_v = LINK_LAST;
         default:  put_v = LINK_FREE;
      endcase
      nb0 = cur_ff[0] ? {b0[7:4], put_v[11:8]} : put_v[7:0];
      nb1 = cur_ff[0] ? put_v[7:0] : {put_v[11:8], b1[3:0]};
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      cur_in        = cur_ff;
      count_in      = count_ff;
      dirty_in      = dirty_ff;
      q_pop         = 1'b0;
      out_load      = 1'b0;
      rsp_link_in   = 12'd0;
      rsp_byte_in   = 8'd0;
      rsp_status_in = ST_OK;
      put_en        = 1'b0;
      even_we       = 1'b0;
      odd_we        = 1'b0;
      even_wa       = even_rd;
      odd_wa        = odd_rd;
      even_wd       = a_sel[0] ? nb1 : nb0;
      odd_wd        = a_sel[0] ? nb0 : nb1;

      case (state_ff)
         S_IDLE: begin
            if (q_valid && out_free) begin
               q_pop    = 1'b1;
               cmd_in   = q_cmd;
               cur_in   = (q_cmd.op == OP_ALLOC) ? 12'd0 : q_cmd.idx;
               count_in = '0;
               case (q_cmd.op)
                  OP_DONE: begin
                     out_load      = 1'b1;
                     rsp_status_in = q_cmd.status;
                  end
                  OP_LDBYTE: begin
                     out_load = 1'b1;
                     even_wa  = q_cmd.addr[BANK_AW:1];
                     odd_wa   = q_cmd.addr[BANK_AW:1];
                     even_wd  = q_cmd.data;
                     odd_wd   = q_cmd.data;
                     even_we  = !q_cmd.addr[0];
                     odd_we   = q_cmd.addr[0];
                  end
                  default: begin
                     state_in = S_READ;
                  end
               endcase
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            state_in = S_IDLE;
            case (cmd_ff.op)
               OP_RLINK: begin
                  out_load    = 1'b1;
                  rsp_link_in = entry_val;
               end
               OP_WLINK: begin
                  put_en   = 1'b1;
                  out_load = 1'b1;
               end
               OP_ALLOC: begin
                  if (entry_val == LINK_END_TABLE) begin
                     out_load      = 1'b1;
                     rsp_status_in = ST_NO_FREE;
                  end else if (entry_val == LINK_FREE) begin
                     put_en      = 1'b1;
                     out_load    = 1'b1;
                     rsp_link_in = cur_ff;
                  end else if (cur_ff == 12'(ENTRIES - 1)) begin
                     out_load      = 1'b1;
                     rsp_status_in = ST_NO_FREE;
                  end else begin
                     cur_in   = cur_ff + 12'd1;
                     state_in = S_READ;
                  end
               end
               OP_FREE: begin
                  put_en = 1'b1;
                  if (entry_val == LINK_LAST) begin
                     out_load = 1'b1;
                  end else if (count_ff == CNT_W'(ENTRIES - 1)) begin
                     out_load      = 1'b1;
                     rsp_status_in = ST_UNTERM;
                  end else if ({1'b0, entry_val} >= 13'(ENTRIES)) begin
                     out_load      = 1'b1;
                     rsp_status_in = ST_RANGE;
                  end else begin
                     cur_in   = entry_val;
                     count_in = count_ff + CNT_W'(1);
                     state_in = S_READ;
                  end
               end
               OP_RDBYTE: begin
                  out_load    = 1'b1;
                  rsp_byte_in = b0;
               end
               default: begin
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (put_en) begin
         even_we  = 1'b1;
         odd_we   = 1'b1;
         dirty_in = 1'b1;
      end
      rsp_dirty_in = dirty_in;

      if (out_load) rsp_valid_in = 1'b1;
      else rsp_valid_in = rsp_valid_ff && rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dirty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff   <= cmd_in;
      cur_ff   <= cur_in;
      count_ff <= count_in;
      if (out_load) begin
         rsp_link_ff   <= rsp_link_in;
         rsp_byte_ff   <= rsp_byte_in;
         rsp_status_ff <= rsp_status_in;
         rsp_dirty_ff  <= rsp_dirty_in;
      end
   end

   fce_ram #(
      .WIDTH (8),
      .DEPTH (BANK_DEPTH)
   ) u_even_bank (
      .clock   (clock),
      .wr_en   (even_we),
      .wr_addr (even_wa),
      .wr_data (even_wd),
      .rd_addr (even_rd),
      .rd_data (even_q)
   );

   fce_ram #(
      .WIDTH (8),
      .DEPTH (BANK_DEPTH)
   ) u_odd_bank (
      .clock   (clock),
      .wr_en   (odd_we),
      .wr_addr (odd_wa),
      .wr_data (odd_wd),
      .rd_addr (odd_rd),
      .rd_data (odd_q)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_link_out    = rsp_link_ff;
   assign rsp_byte_out    = rsp_byte_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_table_dirty = rsp_dirty_ff;

endmodule

[rtl/core/packed_12bit_fat_chain_engine.sv]
// Top level of the packed 12-bit link table engine.
// A request word is registered into the command queue; range errors, no-ops and byte loads
// answer in the cycle after they leave the queue, link reads, link writes and byte reads after
// the read and evaluate states. Allocate repeats these states per entry scanned, free chain
// per entry freed; one command runs in the back part at a time.
// Reset clears the control state and the dirty flag; the byte store holds no defined contents
// until it is loaded, and there is no clearing pass.
module packed_12bit_fat_chain_engine import fce_pkg::*; #(
   parameter int ENTRIES = FCE_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [11:0] req_entry_index,
   input  logic [11:0] req_link_value,
   input  logic [12:0] req_byte_address,
   input  logic [7:0]  req_byte_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_link_out,
   output logic [7:0]  rsp_byte_out,
   output logic [1:0]  rsp_status,
   output logic        rsp_table_dirty
);

   logic    q_full;
   logic    q_push;
   logic    q_valid;
   logic    q_pop;
   cmd_type push_cmd;
   cmd_type head_cmd;

   fce_front #(
      .ENTRIES (ENTRIES)
   ) u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_entry_index  (req_entry_index),
      .req_link_value   (req_link_value),
      .req_byte_address (req_byte_address),
      .req_byte_data    (req_byte_data),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_cmd            (push_cmd)
   );

   fce_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .cmd_in  (push_cmd),
      .full    (q_full),
      .valid   (q_valid),
      .cmd_out (head_cmd),
      .pop     (q_pop)
   );

   fce_back #(
      .ENTRIES (ENTRIES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_cmd           (head_cmd),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_link_out    (rsp_link_out),
      .rsp_byte_out    (rsp_byte_out),
      .rsp_status      (rsp_status),
      .rsp_table_dirty (rsp_table_dirty)
   );

endmodule
